// ===== design/icmp_pkg.sv =====
// Shared types and constants for the ICMP echo responder.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package icmp_pkg;

    localparam int unsigned WORD_W = 64;

    // ICMP header codes
    localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
    localparam logic [7:0] CODE_ECHO         = 8'd0;

    // Ones'-complement sum of a message whose checksum is correct
    localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

    localparam logic [3:0] BYTES_PER_WORD = 4'd8;

    // Input transaction: one message word
    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [3:0]        byte_count;
        logic              last_word;
        logic [31:0]       source_addr;
    } t_in_item;

    // Output transaction: one reply word
    typedef struct packed {
        logic [WORD_W-1:0] reply_word;
        logic [3:0]        reply_bytes;
        logic              reply_last;
        logic [31:0]       dest_addr;
    } t_out_item;

    // Reply launch from the receive side to the replay side
    typedef struct packed {
        logic        start;
        logic [15:0] csum;
        logic [3:0]  tail_bytes;
        logic [31:0] dest_addr;
    } t_reply_cmd;

endpackage

`default_nettype wire

// ===== design/icmp_store.sv =====
// Message store: one write port, one read port with registered read data.
// Depends on icmp_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module icmp_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [AW-1:0]               i_wr_addr,
    input  wire logic [icmp_pkg::WORD_W-1:0] i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [AW-1:0]               i_rd_addr,
    output logic      [icmp_pkg::WORD_W-1:0] o_rd_data
);

    logic [icmp_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [icmp_pkg::WORD_W-1:0] r_rd_data;

    // Write incoming words, read one entry per cycle while read is enabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/icmp_rx.sv =====
// Receive side: normalizes each word, keeps length and running checksums,
// writes the store and decides whether a reply goes out. Depends on icmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icmp_rx #(
    parameter int unsigned MAX_BYTES = 512,
    parameter int unsigned AW        = 6,
    parameter int unsigned LW        = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire icmp_pkg::t_in_item          i_item,
    output logic                             o_busy,
    output logic                             o_wr_en,
    output logic      [AW-1:0]               o_wr_addr,
    output logic      [icmp_pkg::WORD_W-1:0] o_wr_data,
    output icmp_pkg::t_reply_cmd             o_cmd,
    output logic      [AW-1:0]               o_last_addr
);

    // Fold a sum of up to eight 16-bit terms with end-around carry
    function automatic logic [15:0] oc_fold(input logic [18:0] s);
        logic [16:0] t;
        t = 17'(s[15:0]) + 17'(s[18:16]);
        return t[15:0] + 16'(t[16]);
    endfunction

    logic [LW-1:0]               r_len;
    logic [15:0]                 r_verify;
    logic [15:0]                 r_reply;
    logic                        r_too_long;
    logic                        r_check;
    logic                        r_type_ok;
    logic [31:0]                 r_src;

    logic [3:0]                  w_cnt;
    logic [icmp_pkg::WORD_W-1:0] w_word;
    logic [LW:0]                 w_len_sum;
    logic                        w_fits;
    logic                        w_first;
    logic                        w_store;
    logic [15:0]                 w_h0, w_h1, w_h2, w_h3;
    logic [18:0]                 w_vsum;
    logic [18:0]                 w_rsum;
    logic [LW-1:0]               w_len_m1;

    // Normalize byte count and zero the bytes past it
    always_comb begin
        if (!i_item.last_word || i_item.byte_count == 4'd0 ||
            i_item.byte_count > icmp_pkg::BYTES_PER_WORD) begin
            w_cnt = icmp_pkg::BYTES_PER_WORD;
        end else begin
            w_cnt = i_item.byte_count;
        end
        for (int b = 0; b < 8; b++) begin
            w_word[63-8*b -: 8] = (4'(b) < w_cnt) ? i_item.data_word[63-8*b -: 8] : 8'd0;
        end
    end

    assign w_len_sum = {1'b0, r_len} + (LW+1)'(w_cnt);
    assign w_fits    = w_len_sum <= (LW+1)'(MAX_BYTES);
    assign w_first   = r_len == '0;
    assign w_store   = i_accept && !r_too_long && w_fits;

    // Sum the four halfwords; the reply sum skips type, code and checksum
    assign w_h0   = w_word[63:48];
    assign w_h1   = w_word[47:32];
    assign w_h2   = w_word[31:16];
    assign w_h3   = w_word[15:0];
    assign w_vsum = 19'(r_verify) + 19'(w_h0) + 19'(w_h1) + 19'(w_h2) + 19'(w_h3);
    assign w_rsum = 19'(r_reply) + (w_first ? 19'd0 : 19'(w_h0) + 19'(w_h1))
                  + 19'(w_h2) + 19'(w_h3);

    // Write port toward the store
    assign o_wr_en   = w_store;
    assign o_wr_addr = AW'(r_len >> 3);
    assign o_wr_data = w_word;

    // Per-message state; clear after the check cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_verify   <= '0;
            r_reply    <= '0;
            r_too_long <= 1'b0;
            r_check    <= 1'b0;
            r_type_ok  <= 1'b0;
        end else if (r_check) begin
            r_len      <= '0;
            r_verify   <= '0;
            r_reply    <= '0;
            r_too_long <= 1'b0;
            r_check    <= 1'b0;
        end else if (i_accept) begin
            if (!r_too_long) begin
                if (!w_fits) begin
                    r_too_long <= 1'b1;
                end else begin
                    r_len    <= w_len_sum[LW-1:0];
                    r_verify <= oc_fold(w_vsum);
                    r_reply  <= oc_fold(w_rsum);
                    if (w_first) begin
                        r_type_ok <= w_word[63:56] == icmp_pkg::TYPE_ECHO_REQUEST;
                    end
                end
            end
            r_check <= i_item.last_word;
        end
    end

    // Sample the sender on the last word
    always_ff @(posedge i_clk) begin
        if (i_accept && i_item.last_word) begin
            r_src <= i_item.source_addr;
        end
    end

    // Verdict and reply launch during the check cycle
    assign w_len_m1 = r_len - LW'(1);

    always_comb begin
        o_cmd.start      = r_check && !r_too_long && (r_len >= LW'(8)) &&
                           (r_verify == icmp_pkg::SUM_ALL_ONES) && r_type_ok;
        o_cmd.csum       = ~r_reply;
        o_cmd.tail_bytes = (r_len[2:0] == 3'd0) ? icmp_pkg::BYTES_PER_WORD
                                                : {1'b0, r_len[2:0]};
        o_cmd.dest_addr  = r_src;
    end

    assign o_last_addr = AW'(w_len_m1 >> 3);
    assign o_busy      = r_check;

endmodule

`default_nettype wire

// ===== design/icmp_tx.sv =====
// Replay side: reads stored words in order, patches the header of the first,
// and holds finished words in an output register plus a skid register. Depends on icmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icmp_tx #(
    parameter int unsigned AW = 6
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire icmp_pkg::t_reply_cmd        i_cmd,
    input  wire logic [AW-1:0]               i_last_addr,
    output logic                             o_rd_en,
    output logic      [AW-1:0]               o_rd_addr,
    input  wire logic [icmp_pkg::WORD_W-1:0] i_rd_data,
    output logic                             o_reading,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output icmp_pkg::t_out_item              o_item
);

    logic                r_active;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       r_last_addr;
    logic [15:0]         r_csum;
    logic [3:0]          r_tail;
    logic [31:0]         r_dest;
    logic                r_pend;
    logic                r_pend_first;
    logic                r_pend_last;
    logic                r_out_valid;
    icmp_pkg::t_out_item r_out;
    logic                r_skid_valid;
    icmp_pkg::t_out_item r_skid;

    logic                w_pop;
    logic [1:0]          w_occ;
    logic                w_issue;
    icmp_pkg::t_out_item w_arr;

    // Issue a read only when the arriving word is sure to find a free slot
    assign w_pop   = r_out_valid && i_ready;
    assign w_occ   = 2'(r_out_valid) + 2'(r_skid_valid) + 2'(r_pend) - 2'(w_pop);
    assign w_issue = r_active && (w_occ < 2'd2);

    // Build the reply word from the read data
    always_comb begin
        if (r_pend_first) begin
            w_arr.reply_word = {icmp_pkg::TYPE_ECHO_REPLY, icmp_pkg::CODE_ECHO,
                                r_csum, i_rd_data[31:0]};
        end else begin
            w_arr.reply_word = i_rd_data;
        end
        w_arr.reply_bytes = r_pend_last ? r_tail : icmp_pkg::BYTES_PER_WORD;
        w_arr.reply_last  = r_pend_last;
        w_arr.dest_addr   = r_dest;
    end

    // Read sequencer and output buffering
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_active    <= 1'b1;
                r_addr      <= '0;
                r_last_addr <= i_last_addr;
                r_csum      <= i_cmd.csum;
                r_tail      <= i_cmd.tail_bytes;
                r_dest      <= i_cmd.dest_addr;
            end else if (w_issue) begin
                r_addr <= r_addr + AW'(1);
                if (r_addr == r_last_addr) begin
                    r_active <= 1'b0;
                end
            end
            r_pend       <= w_issue;
            r_pend_first <= r_addr == '0;
            r_pend_last  <= r_addr == r_last_addr;

            if (w_pop) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= r_pend;
                    r_skid       <= w_arr;
                end else begin
                    r_out_valid <= r_pend;
                    r_out       <= w_arr;
                end
            end else if (r_pend) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                    r_skid       <= w_arr;
                end else begin
                    r_out_valid <= 1'b1;
                    r_out       <= w_arr;
                end
            end
        end
    end

    assign o_rd_en   = w_issue;
    assign o_rd_addr = r_addr;
    assign o_reading = r_active || r_pend;
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

endmodule

`default_nettype wire

// ===== design/icmp_echo_responder.sv =====
// Top level of the ICMP echo responder: receive side, message store, replay side.
// Depends on icmp_pkg, icmp_rx, icmp_store and icmp_tx.
//
//  channel | handshake                 | payload
//  --------+---------------------------+------------------------------------
//  in      | i_in_valid / o_in_ready   | i_in_item  (icmp_pkg::t_in_item)
//  out     | o_out_valid / i_out_ready | o_out_item (icmp_pkg::t_out_item)
//
// Message words enter at one per cycle while a message is being received.
// The cycle after the last word is a check cycle with o_in_ready low.
// A reply of N words is read from the single store read port at one word per
// cycle while the output buffer has room; each word passes through the store's
// read-data register and then the output or skid register. o_in_ready returns
// the cycle after the last read data arrives, holding off input through replay.
// Output stalls back up through a two-word buffer into the store reads.
// Synchronous active-low reset clears all control state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_responder #(
    parameter int unsigned MAX_BYTES = 512
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire icmp_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output icmp_pkg::t_out_item       o_out_item
);

    localparam int unsigned DEPTH = (MAX_BYTES + 7) / 8;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LW    = $clog2(MAX_BYTES + 1);

    logic                        w_accept;
    logic                        w_rx_busy;
    logic                        w_tx_reading;
    logic                        w_wr_en;
    logic [AW-1:0]               w_wr_addr;
    logic [icmp_pkg::WORD_W-1:0] w_wr_data;
    logic                        w_rd_en;
    logic [AW-1:0]               w_rd_addr;
    logic [icmp_pkg::WORD_W-1:0] w_rd_data;
    icmp_pkg::t_reply_cmd        w_cmd;
    logic [AW-1:0]               w_last_addr;

    // Hold off input during the check cycle and while the store is being read
    assign o_in_ready = !w_rx_busy && !w_tx_reading;
    assign w_accept   = i_in_valid && o_in_ready;

    icmp_rx #(
        .MAX_BYTES (MAX_BYTES),
        .AW        (AW),
        .LW        (LW)
    ) u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_item),
        .o_busy      (w_rx_busy),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_cmd       (w_cmd),
        .o_last_addr (w_last_addr)
    );

    icmp_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    icmp_tx #(
        .AW (AW)
    ) u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_last_addr (w_last_addr),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_reading   (w_tx_reading),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out_item)
    );

endmodule

`default_nettype wire

// ===== design/icmp_chk.sv =====
// Port-level checker for the ICMP echo responder, bound to the top level.
// Depends on icmp_pkg for the transaction types.
`timescale 1ns / 1ps
`default_nettype none

module icmp_chk (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire icmp_pkg::t_in_item  i_in_item,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire icmp_pkg::t_out_item i_out_item
);

    // A stalled reply transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("reply transaction changed while stalled");

    // Valid byte count of every reply word is 1 to 8
    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_item.reply_bytes != 4'd0 &&
                        i_out_item.reply_bytes <= icmp_pkg::BYTES_PER_WORD)
        else $error("reply byte count out of range");

    // Only the final reply word may be short
    a_full_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.reply_last |->
            i_out_item.reply_bytes == icmp_pkg::BYTES_PER_WORD)
        else $error("short reply word before the last");

    // The cycle after a final message word is a check cycle
    a_check_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_item.last_word |=> !i_in_ready)
        else $error("input taken during the check cycle");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("reply valid right after reset");

endmodule

bind icmp_echo_responder icmp_chk u_icmp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_item  (o_out_item)
);

`default_nettype wire
